// ===== hw/rtl/arpb_pkg.sv =====
// admin request byte parser package: transaction structs, parse phase encoding
// and field codes shared by all parser modules
// no dependencies
package arpb_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       new_message;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] message_type;
      logic [7:0] command_code;
      logic [7:0] admin_flag;
      logic [1:0] field_kind;
      logic [7:0] field_byte;
      logic [7:0] field_index;
      logic [7:0] name_length;
      logic [7:0] pass_length;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_TYPE      = 4'd0,
      PH_CMD_GET   = 4'd1,
      PH_CMD_USER  = 4'd2,
      PH_CMD_SNIFF = 4'd3,
      PH_ADMIN     = 4'd4,
      PH_ULEN      = 4'd5,
      PH_UNAME     = 4'd6,
      PH_PLEN      = 4'd7,
      PH_PASSWD    = 4'd8,
      PH_DONE      = 4'd9,
      PH_ERR_LEN   = 4'd10,
      PH_ERR_TYPE  = 4'd11,
      PH_ERR_CMD   = 4'd12,
      PH_ERR_ADMIN = 4'd13
   } phase_type;

   localparam logic [2:0] STATUS_BUSY      = 3'd0;
   localparam logic [2:0] STATUS_DONE      = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd2;
   localparam logic [2:0] STATUS_BAD_TYPE  = 3'd3;
   localparam logic [2:0] STATUS_BAD_CMD   = 3'd4;
   localparam logic [2:0] STATUS_BAD_ADMIN = 3'd5;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_USERNAME = 2'd1;
   localparam logic [1:0] KIND_PASSWORD = 2'd2;

   localparam logic [7:0] MSG_GET   = 8'h00;
   localparam logic [7:0] MSG_USER  = 8'h01;
   localparam logic [7:0] MSG_SNIFF = 8'h02;
   localparam logic [7:0] MSG_QUIT  = 8'h03;

   localparam logic [7:0] USER_CMD_ADMIN = 8'h00;
   localparam logic [7:0] USER_CMD_NAME  = 8'h01;
   localparam logic [7:0] USER_CMD_BOTH  = 8'h02;

   localparam logic [7:0] GET_CMD_LIMIT   = 8'd4;
   localparam logic [7:0] SNIFF_CMD_LIMIT = 8'd2;
   localparam logic [7:0] ADMIN_FLAG_MAX  = 8'd1;

endpackage

// ===== hw/rtl/arpb_in_reg.sv =====
// input register stage for request transactions
// depends on arpb_pkg
module arpb_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  arpb_pkg::req_type req_data,
   input  logic             advance,
   output logic             held_valid,
   output arpb_pkg::req_type held_data
);
   import arpb_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready  = !valid_ff || advance;
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

// ===== hw/rtl/arpb_parse_core.sv =====
// parse state machine: phase and field registers, next state and result logic
// depends on arpb_pkg
module arpb_parse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  arpb_pkg::req_type  in_data,
   output arpb_pkg::rsp_type  result
);
   import arpb_pkg::*;

   phase_type  phase_ff, phase_in, base_phase;
   logic [7:0] type_ff, type_in, base_type;
   logic [7:0] cmd_ff, cmd_in, base_cmd;
   logic [7:0] admin_ff, admin_in, base_admin;
   logic [7:0] nlen_ff, nlen_in, base_nlen;
   logic [7:0] plen_ff, plen_in, base_plen;
   logic [7:0] count_ff, count_in, base_count;
   logic [7:0] expect_ff, expect_in, base_expect;
   logic [7:0] count_plus;
   logic [7:0] c;

   assign c = in_data.byte_value;

   // new message restarts from the cleared state
   always_comb begin
      if (in_data.new_message) begin
         base_phase  = PH_TYPE;
         base_type   = '0;
         base_cmd    = '0;
         base_admin  = '0;
         base_nlen   = '0;
         base_plen   = '0;
         base_count  = '0;
         base_expect = '0;
      end else begin
         base_phase  = phase_ff;
         base_type   = type_ff;
         base_cmd    = cmd_ff;
         base_admin  = admin_ff;
         base_nlen   = nlen_ff;
         base_plen   = plen_ff;
         base_count  = count_ff;
         base_expect = expect_ff;
      end
   end

   assign count_plus = base_count + 8'd1;

   always_comb begin
      phase_in  = base_phase;
      type_in   = base_type;
      cmd_in    = base_cmd;
      admin_in  = base_admin;
      nlen_in   = base_nlen;
      plen_in   = base_plen;
      count_in  = base_count;
      expect_in = base_expect;
      case (base_phase)
         PH_TYPE: begin
            type_in = c;
            if (c == MSG_GET) begin
               phase_in = PH_CMD_GET;
            end else if (c == MSG_USER) begin
               phase_in = PH_CMD_USER;
            end else if (c == MSG_SNIFF) begin
               phase_in = PH_CMD_SNIFF;
            end else if (c == MSG_QUIT) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_ERR_TYPE;
            end
         end
         PH_CMD_GET: begin
            cmd_in   = c;
            phase_in = (c < GET_CMD_LIMIT) ? PH_DONE : PH_ERR_CMD;
         end
         PH_CMD_SNIFF: begin
            cmd_in   = c;
            phase_in = (c < SNIFF_CMD_LIMIT) ? PH_DONE : PH_ERR_CMD;
         end
         PH_CMD_USER: begin
            cmd_in = c;
            if (c == USER_CMD_ADMIN) begin
               phase_in = PH_ADMIN;
            end else if (c == USER_CMD_NAME || c == USER_CMD_BOTH) begin
               phase_in = PH_ULEN;
            end else begin
               phase_in = PH_ERR_CMD;
            end
         end
         PH_ADMIN: begin
            admin_in = c;
            phase_in = (c <= ADMIN_FLAG_MAX) ? PH_ULEN : PH_ERR_ADMIN;
         end
         PH_ULEN, PH_PLEN: begin
            if (c == 8'd0) begin
               phase_in = PH_ERR_LEN;
            end else begin
               if (base_phase == PH_ULEN) begin
                  nlen_in  = c;
                  phase_in = PH_UNAME;
               end else begin
                  plen_in  = c;
                  phase_in = PH_PASSWD;
               end
               count_in  = 8'd0;
               expect_in = c;
            end
         end
         PH_UNAME, PH_PASSWD: begin
            count_in = count_plus;
            if (count_plus >= base_expect) begin
               if (base_phase == PH_PASSWD || base_cmd == USER_CMD_NAME) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_PLEN;
               end
            end
         end
         PH_DONE, PH_ERR_LEN, PH_ERR_TYPE, PH_ERR_CMD, PH_ERR_ADMIN: begin
            phase_in = base_phase;
         end
         default: begin
            phase_in = PH_ERR_LEN;
         end
      endcase
   end

   always_comb begin
      case (phase_in)
         PH_DONE:      result.status = STATUS_DONE;
         PH_ERR_LEN:   result.status = STATUS_BAD_LEN;
         PH_ERR_TYPE:  result.status = STATUS_BAD_TYPE;
         PH_ERR_CMD:   result.status = STATUS_BAD_CMD;
         PH_ERR_ADMIN: result.status = STATUS_BAD_ADMIN;
         default:      result.status = STATUS_BUSY;
      endcase
      result.message_type = type_in;
      result.command_code = cmd_in;
      result.admin_flag   = admin_in;
      result.name_length  = nlen_in;
      result.pass_length  = plen_in;
      if (base_phase == PH_UNAME || base_phase == PH_PASSWD) begin
         result.field_kind  = (base_phase == PH_UNAME) ? KIND_USERNAME : KIND_PASSWORD;
         result.field_byte  = c;
         result.field_index = base_count;
      end else begin
         result.field_kind  = KIND_NONE;
         result.field_byte  = 8'd0;
         result.field_index = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         type_ff   <= '0;
         cmd_ff    <= '0;
         admin_ff  <= '0;
         nlen_ff   <= '0;
         plen_ff   <= '0;
         count_ff  <= '0;
         expect_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         cmd_ff    <= cmd_in;
         admin_ff  <= admin_in;
         nlen_ff   <= nlen_in;
         plen_ff   <= plen_in;
         count_ff  <= count_in;
         expect_ff <= expect_in;
      end
   end

endmodule

// ===== hw/rtl/arpb_out_reg.sv =====
// result register holding one response transaction until it is taken
// depends on arpb_pkg
module arpb_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              held_valid,
   output logic              advance,
   input  arpb_pkg::rsp_type  result,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpb_pkg::rsp_type  rsp_data
);
   import arpb_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign advance   = held_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

endmodule

// ===== hw/rtl/admin_request_byte_parser.sv =====
// admin request byte parser top level: input register, parse core, result register
// path: an accepted request is held in the input register, then its response in the result register;
// that move waits while an earlier response is not yet taken from the result register
// throughput: one transaction per cycle, stalled while a response waits untaken in the result register
// reset: synchronous, clears both valid flags and returns the parser to the type byte
// depends on arpb_pkg, arpb_in_reg, arpb_parse_core, arpb_out_reg
module admin_request_byte_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arpb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpb_pkg::rsp_type  rsp_data
);
   import arpb_pkg::*;

   logic    advance;
   logic    held_valid;
   req_type held_data;
   rsp_type result;

   arpb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   arpb_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_data (held_data),
      .result  (result)
   );

   arpb_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .advance    (advance),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
